// ===== rtl/iadc_pkg.sv =====
package iadc_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SETTLE_W  = 8;
  localparam int RAW_W     = 16;
  localparam int POT_IDX_W = 2;
  localparam int COUNT_W   = 32;
  localparam int BYTE_W    = 8;

  localparam logic [SAMPLE_W-1:0] MIDSCALE     = 12'd2048;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd2;

  localparam int DEF_AVERAGE_TAPS     = 4;
  localparam int DEF_POT_COUNT        = 3;
  localparam int DEF_SAMPLES_PER_HOLD = 8;

  // pot path outcome for one word, values as they stand after the word
  typedef struct packed {
    logic                 discarded;
    logic                 updated;
    logic [POT_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  value;
    logic [POT_IDX_W-1:0] mux_select;
    logic [COUNT_W-1:0]   switch_count;
    logic [COUNT_W-1:0]   discard_count;
  } pot_result_t;

endpackage

// ===== rtl/iadc_audio_avg.sv =====
module iadc_audio_avg
  import iadc_pkg::*;
#(
  parameter int AVERAGE_TAPS = DEF_AVERAGE_TAPS,
  localparam int SLOT_W = $clog2(AVERAGE_TAPS),
  localparam int SUM_W  = SAMPLE_W + $clog2(AVERAGE_TAPS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]    sum_after
);

  logic [SAMPLE_W-1:0] history [AVERAGE_TAPS];
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   slot_next;

  always_comb begin
    sum_next  = sum;
    slot_next = slot;
    if (en) begin
      // oldest entry is part of the sum, so the subtract never goes negative
      sum_next  = sum - SUM_W'(history[slot]) + SUM_W'(sample);
      slot_next = (slot == SLOT_W'(AVERAGE_TAPS - 1)) ? '0 : SLOT_W'(slot + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVERAGE_TAPS; i++) begin
        history[i] <= MIDSCALE;
      end
      sum  <= SUM_W'(AVERAGE_TAPS * 2048);
      slot <= '0;
    end else begin
      if (en) begin
        history[slot] <= sample;
      end
      sum  <= sum_next;
      slot <= slot_next;
    end
  end

  assign sum_after = sum_next;

endmodule

// ===== rtl/iadc_pot_scan.sv =====
module iadc_pot_scan
  import iadc_pkg::*;
#(
  parameter int POT_COUNT        = DEF_POT_COUNT,
  parameter int SAMPLES_PER_HOLD = DEF_SAMPLES_PER_HOLD
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SETTLE_W-1:0] settle_discard,
  output pot_result_t         result
);

  localparam int P_L     = $clog2(SAMPLES_PER_HOLD);
  localparam int PSUM_W  = SAMPLE_W + P_L;
  localparam int P_SHIFT = PSUM_W + P_L;
  localparam int RECIP_W = PSUM_W + 1;
  localparam int PROD_W  = PSUM_W + RECIP_W;
  localparam int CNT_W   = (SAMPLES_PER_HOLD > 1) ? $clog2(SAMPLES_PER_HOLD) : 1;
  // reciprocal of the hold length, exact for every sum below 2**PSUM_W
  localparam logic [RECIP_W-1:0] P_RECIP =
    RECIP_W'((2 ** P_SHIFT + SAMPLES_PER_HOLD - 1) / SAMPLES_PER_HOLD);

  logic [PSUM_W-1:0]    pot_sum, pot_sum_next, pot_acc;
  logic [PROD_W-1:0]    mean_prod;
  logic [CNT_W-1:0]     sample_count, sample_count_next;
  logic [SETTLE_W-1:0]  discard_left, discard_left_next;
  logic [POT_IDX_W-1:0] active_pot, active_pot_next;
  logic [COUNT_W-1:0]   switches_total, switches_total_next;
  logic [COUNT_W-1:0]   discards_total, discards_total_next;

  assign pot_acc   = pot_sum + PSUM_W'(sample);
  assign mean_prod = PROD_W'(pot_acc) * PROD_W'(P_RECIP);

  always_comb begin
    pot_sum_next        = pot_sum;
    sample_count_next   = sample_count;
    discard_left_next   = discard_left;
    active_pot_next     = active_pot;
    switches_total_next = switches_total;
    discards_total_next = discards_total;
    result.discarded    = 1'b0;
    result.updated      = 1'b0;
    result.index        = '0;
    result.value        = '0;
    if (en) begin
      if (discard_left != '0) begin
        discard_left_next   = discard_left - 1'b1;
        discards_total_next = discards_total + 1'b1;
        result.discarded    = 1'b1;
      end else if (sample_count == CNT_W'(SAMPLES_PER_HOLD - 1)) begin
        result.updated      = 1'b1;
        result.index        = active_pot;
        result.value        = mean_prod[P_SHIFT +: SAMPLE_W];
        pot_sum_next        = '0;
        sample_count_next   = '0;
        discard_left_next   = settle_discard;
        switches_total_next = switches_total + 1'b1;
        active_pot_next     = (active_pot == POT_IDX_W'(POT_COUNT - 1)) ? '0 :
                              POT_IDX_W'(active_pot + 1'b1);
      end else begin
        pot_sum_next      = pot_acc;
        sample_count_next = CNT_W'(sample_count + 1'b1);
      end
    end
    result.mux_select    = active_pot_next;
    result.switch_count  = switches_total_next;
    result.discard_count = discards_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pot_sum        <= '0;
      sample_count   <= '0;
      discard_left   <= SETTLE_RESET;
      active_pot     <= '0;
      switches_total <= '0;
      discards_total <= '0;
    end else begin
      pot_sum        <= pot_sum_next;
      sample_count   <= sample_count_next;
      discard_left   <= discard_left_next;
      active_pot     <= active_pot_next;
      switches_total <= switches_total_next;
      discards_total <= discards_total_next;
    end
  end

endmodule

// ===== rtl/interleaved_adc_audio_pot_conditioner.sv =====
// Interleaved ADC conditioner: audio moving average and multiplexed pot scanner.
// Input channel in_valid/in_ready carries one ADC word (raw_word, low 12 bits
// used). Words alternate between the pot path and the audio path, pot first.
// Output channel out_valid/out_ready carries exactly one result word per input
// word: audio average, pot update flags and value, mux select and counters.
// Config channel cfg_valid/cfg_ready writes settle_discard and is always ready;
// the user must write it only while the block is idle, which the block itself
// does not enforce. A new value is used at the next mux switch.
// A word accepted on the input is held in the input register and moves into the
// result register once that register is free or its result is being taken. The block
// takes one word per cycle while the receiver does not stall, as the audio running sum
// and the pot accumulator are updated combinationally between the two registers.
// Reset (rst, synchronous) empties both registers, refills the audio history
// with midscale, selects pot 0, clears the counters and sets settle_discard
// to 2. When the receiver stalls the result holds, the input register still
// takes one more word, and in_ready then drops until the result is taken.
module interleaved_adc_audio_pot_conditioner
  import iadc_pkg::*;
#(
  parameter int AVERAGE_TAPS     = DEF_AVERAGE_TAPS,
  parameter int POT_COUNT        = DEF_POT_COUNT,
  parameter int SAMPLES_PER_HOLD = DEF_SAMPLES_PER_HOLD
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [RAW_W-1:0]     raw_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SETTLE_W-1:0]  settle_discard,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  audio_average,
  output logic                 sample_was_pot,
  output logic                 settle_discarded,
  output logic                 pot_updated,
  output logic [POT_IDX_W-1:0] pot_slot,
  output logic [SAMPLE_W-1:0]  pot_value,
  output logic [BYTE_W-1:0]    pot_value_byte,
  output logic [POT_IDX_W-1:0] mux_select,
  output logic [COUNT_W-1:0]   switch_count,
  output logic [COUNT_W-1:0]   discard_count
);

  localparam int A_L     = $clog2(AVERAGE_TAPS);
  localparam int ASUM_W  = SAMPLE_W + A_L;
  localparam int A_SHIFT = ASUM_W + A_L;
  localparam int A_RW    = ASUM_W + 1;
  localparam int A_PW    = ASUM_W + A_RW;
  localparam logic [A_RW-1:0] A_RECIP =
    A_RW'((2 ** A_SHIFT + AVERAGE_TAPS - 1) / AVERAGE_TAPS);

  // byte scale: v*255/4095 = v*17/273, and v*17 fits in 17 bits
  localparam int B_X_W   = 17;
  localparam int B_SHIFT = 26;
  localparam int B_RW    = 18;
  localparam int B_PW    = B_X_W + B_RW;
  localparam logic [B_RW-1:0] B_RECIP = B_RW'((2 ** B_SHIFT + 273 - 1) / 273);

  logic                settle_reg;
  logic [SETTLE_W-1:0] settle_value;
  logic                word_valid;
  logic [SAMPLE_W-1:0] word;
  logic                expect_pot;
  logic                advance;
  logic [ASUM_W-1:0]   audio_sum_after;
  logic [ASUM_W-1:0]   audio_sum_q;
  logic                was_pot_q;
  pot_result_t         pot_res;
  pot_result_t         pot_q;
  logic [A_PW-1:0]     avg_prod;
  logic [B_X_W-1:0]    byte_x;
  logic [B_PW-1:0]     byte_prod;

  assign cfg_ready  = 1'b1;
  assign settle_reg = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_value <= SETTLE_RESET;
    end else if (settle_reg) begin
      settle_value <= settle_discard;
    end
  end

  // input word moves into the result register whenever that slot frees up
  assign advance  = word_valid && (!out_valid || out_ready);
  assign in_ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      expect_pot <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        word_valid <= 1'b1;
      end else if (advance) begin
        word_valid <= 1'b0;
      end
      if (advance) begin
        expect_pot <= !expect_pot;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= raw_word[SAMPLE_W-1:0];
    end
    if (advance) begin
      audio_sum_q <= audio_sum_after;
      was_pot_q   <= expect_pot;
      pot_q       <= pot_res;
    end
  end

  iadc_audio_avg #(
    .AVERAGE_TAPS(AVERAGE_TAPS)
  ) u_audio (
    .clk      (clk),
    .rst      (rst),
    .en       (advance && !expect_pot),
    .sample   (word),
    .sum_after(audio_sum_after)
  );

  iadc_pot_scan #(
    .POT_COUNT       (POT_COUNT),
    .SAMPLES_PER_HOLD(SAMPLES_PER_HOLD)
  ) u_pot (
    .clk           (clk),
    .rst           (rst),
    .en            (advance && expect_pot),
    .sample        (word),
    .settle_discard(settle_value),
    .result        (pot_res)
  );

  assign avg_prod  = A_PW'(audio_sum_q) * A_PW'(A_RECIP);
  assign byte_x    = {1'b0, pot_q.value, 4'b0000} + B_X_W'(pot_q.value);
  assign byte_prod = B_PW'(byte_x) * B_PW'(B_RECIP);

  assign audio_average    = avg_prod[A_SHIFT +: SAMPLE_W];
  assign sample_was_pot   = was_pot_q;
  assign settle_discarded = pot_q.discarded;
  assign pot_updated      = pot_q.updated;
  assign pot_slot         = pot_q.index;
  assign pot_value        = pot_q.value;
  assign pot_value_byte   = byte_prod[B_SHIFT +: BYTE_W];
  assign mux_select       = pot_q.mux_select;
  assign switch_count     = pot_q.switch_count;
  assign discard_count    = pot_q.discard_count;

  a_discard_on_pot: assert property (@(posedge clk) disable iff (rst)
    out_valid && settle_discarded |-> sample_was_pot && !pot_updated)
    else $error("settle discard flagged on a word that was not a pot word");

  a_update_on_pot: assert property (@(posedge clk) disable iff (rst)
    out_valid && pot_updated |-> sample_was_pot)
    else $error("pot update flagged on an audio word");

  a_mux_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mux_select <= POT_IDX_W'(POT_COUNT - 1))
    else $error("mux select beyond the last pot");

  a_paths_alternate: assert property (@(posedge clk) disable iff (rst)
    advance ##1 (advance && !$past(rst)) |-> pot_res.mux_select == mux_select
      || expect_pot)
    else $error("pot state moved on an audio word");

endmodule

// ===== test/interleaved_adc_audio_pot_conditioner_tb.sv =====
`timescale 1ns / 100ps

module interleaved_adc_audio_pot_conditioner_tb;
  import iadc_pkg::*;

  localparam int TAPS        = DEF_AVERAGE_TAPS;
  localparam int POTS        = DEF_POT_COUNT;
  localparam int HOLD        = DEF_SAMPLES_PER_HOLD;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  audio_avg;
    logic                 was_pot;
    logic                 discarded;
    logic                 updated;
    logic [POT_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  value;
    logic [BYTE_W-1:0]    value_byte;
    logic [POT_IDX_W-1:0] mux;
    logic [COUNT_W-1:0]   switches;
    logic [COUNT_W-1:0]   discards;
  } cond_result_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [RAW_W-1:0]     raw_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [SETTLE_W-1:0]  settle_discard;
  logic                 out_valid;
  logic                 out_ready;
  logic [SAMPLE_W-1:0]  audio_average;
  logic                 sample_was_pot;
  logic                 settle_discarded;
  logic                 pot_updated;
  logic [POT_IDX_W-1:0] pot_slot;
  logic [SAMPLE_W-1:0]  pot_value;
  logic [BYTE_W-1:0]    pot_value_byte;
  logic [POT_IDX_W-1:0] mux_select;
  logic [COUNT_W-1:0]   switch_count;
  logic [COUNT_W-1:0]   discard_count;

  // predictor state
  logic                 pot_turn;
  logic [SAMPLE_W-1:0]  audio_taps [TAPS];
  logic [13:0]          audio_total;
  int unsigned          tap_ptr;
  logic [POT_IDX_W-1:0] active_pot;
  logic [SETTLE_W-1:0]  settle_cfg;
  logic [SETTLE_W-1:0]  settle_left;
  logic [17:0]          pot_acc;
  int unsigned          pot_taken;
  logic [COUNT_W-1:0]   switches_seen;
  logic [COUNT_W-1:0]   discards_seen;

  cond_result_t expected_results[$];
  int           errors;
  int           cycles;
  int           send_idle_pct;
  int           recv_stall_pct;

  interleaved_adc_audio_pot_conditioner u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_word         (raw_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .settle_discard   (settle_discard),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .audio_average    (audio_average),
    .sample_was_pot   (sample_was_pot),
    .settle_discarded (settle_discarded),
    .pot_updated      (pot_updated),
    .pot_slot         (pot_slot),
    .pot_value        (pot_value),
    .pot_value_byte   (pot_value_byte),
    .mux_select       (mux_select),
    .switch_count     (switch_count),
    .discard_count    (discard_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic reset_conditioner_model();
    pot_turn = 1'b1;
    foreach (audio_taps[i]) audio_taps[i] = MIDSCALE;
    audio_total   = 14'(TAPS * MIDSCALE);
    tap_ptr       = 0;
    active_pot    = '0;
    settle_cfg    = SETTLE_RESET;
    settle_left   = SETTLE_RESET;
    pot_acc       = '0;
    pot_taken     = 0;
    switches_seen = '0;
    discards_seen = '0;
  endtask

  function automatic cond_result_t condition_word(input logic [RAW_W-1:0] word);
    cond_result_t        r;
    logic [SAMPLE_W-1:0] sample;
    int unsigned         scaled;
    r      = '0;
    sample = word[SAMPLE_W-1:0];
    r.was_pot = pot_turn;
    if (pot_turn) begin
      if (settle_left != 0) begin
        settle_left--;
        discards_seen++;
        r.discarded = 1'b1;
      end else begin
        pot_acc += sample;
        pot_taken++;
        if (pot_taken >= HOLD) begin
          r.updated    = 1'b1;
          r.index      = active_pot;
          r.value      = SAMPLE_W'(pot_acc / HOLD);
          scaled       = (int'(r.value) * 255) / 4095;
          r.value_byte = BYTE_W'(scaled);
          pot_acc      = '0;
          pot_taken    = 0;
          active_pot   = POT_IDX_W'((int'(active_pot) + 1) % POTS);
          settle_left  = settle_cfg;
          switches_seen++;
        end
      end
    end else begin
      // running sum stays in range once the oldest tap is replaced
      audio_total = audio_total - audio_taps[tap_ptr] + sample;
      audio_taps[tap_ptr] = sample;
      tap_ptr = (tap_ptr + 1) % TAPS;
    end
    pot_turn    = !pot_turn;
    r.audio_avg = SAMPLE_W'(audio_total / TAPS);
    r.mux       = active_pot;
    r.switches  = switches_seen;
    r.discards  = discards_seen;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    cond_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result word expected none, actual audio_average %0d",
                 $time, audio_average);
      end else begin
        want = expected_results.pop_front();
        check_field("audio_average", want.audio_avg, audio_average);
        check_field("sample_was_pot", want.was_pot, sample_was_pot);
        check_field("settle_discarded", want.discarded, settle_discarded);
        check_field("pot_updated", want.updated, pot_updated);
        check_field("pot_slot", want.index, pot_slot);
        check_field("pot_value", want.value, pot_value);
        check_field("pot_value_byte", want.value_byte, pot_value_byte);
        check_field("mux_select", want.mux, mux_select);
        check_field("switch_count", want.switches, switch_count);
        check_field("discard_count", want.discards, discard_count);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("interleaved_adc_audio_pot_conditioner_tb: done, errors");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic [RAW_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_word <= word;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(condition_word(word));
    @(negedge clk);
  endtask

  task automatic close_stream();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // only while idle: every word sent so far has its result back
  task automatic write_settle(input logic [SETTLE_W-1:0] value);
    while (expected_results.size() != 0) @(negedge clk);
    cfg_valid      <= 1'b1;
    settle_discard <= value;
    do @(posedge clk); while (!cfg_ready);
    settle_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int send_pct, input int stall_pct);
    int               style;
    logic [RAW_W-1:0] word;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    style = 0;
    for (int i = 0; i < count; i++) begin
      // runs of all-zero or full-scale samples drive the averages to their ends
      if (i % 16 == 0) style = $urandom_range(0, 5);
      case (style)
        0:       word = {4'($urandom), 12'h000};
        1:       word = {4'($urandom), 12'hFFF};
        default: word = RAW_W'($urandom);
      endcase
      send_word(word);
    end
    close_stream();
  endtask

  // reset settling of two, full-scale pot average with upper bits set, then zero settling
  task automatic test_directed_edges();
    logic [RAW_W-1:0] words[$] = '{
      16'hFFFF, 16'h0FFF, 16'hF000, 16'h0000, 16'h1FFF, 16'hF123,
      16'h2FFF, 16'h0800, 16'h4FFF, 16'hFFFF, 16'h8FFF, 16'hABCD,
      16'h0FFF, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0FFE,
      16'hCFFF, 16'h5A5A, 16'h0000, 16'hA5A5, 16'hF000, 16'h0FFF
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_settle(8'd0);
    foreach (words[i]) send_word(words[i]);
    close_stream();
  endtask

  task automatic test_streaming_zero_settle();
    write_settle(8'd0);
    run_phase(200, 0, 0);
  endtask

  task automatic test_sender_gaps();
    write_settle(8'd1);
    run_phase(200, 54, 0);
  endtask

  task automatic test_receiver_stalls();
    write_settle(SETTLE_W'($urandom_range(0, 15)));
    run_phase(200, 0, 54);
  endtask

  task automatic test_both_sides_idle();
    write_settle(SETTLE_RESET);
    run_phase(200, 28, 28);
  endtask

  task automatic test_random_settle();
    write_settle(SETTLE_W'($urandom_range(0, 15)));
    run_phase(250, 0, 0);
  endtask

  // long enough to finish a full 255-word settle and the average after it
  task automatic test_max_settle();
    write_settle(8'hFF);
    run_phase(620, 0, 54);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    raw_word       = '0;
    cfg_valid      = 1'b0;
    settle_discard = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors         = 0;
    cycles         = 0;
    reset_conditioner_model();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_streaming_zero_settle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    test_random_settle();
    test_max_settle();

    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("interleaved_adc_audio_pot_conditioner_tb: done, clean");
    end else begin
      $display("interleaved_adc_audio_pot_conditioner_tb: done, errors");
    end
    $finish;
  end

endmodule
